/* src/aes_pkg.sv */
`timescale 1ns / 1ps
// Package for the escape sequence stripper: filter state codes, byte constants,
// the classifier result struct and the plain-sequence terminator test.
// No dependencies.
package aes_pkg;

  typedef enum logic [4:0] {
    ST_NORMAL  = 5'b00001,
    ST_ESC     = 5'b00010,
    ST_ESC_LB  = 5'b00100,
    ST_PLAIN   = 5'b01000,
    ST_BRACKET = 5'b10000
  } state_t;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_AT  = 8'h40;
  localparam logic [7:0] CH_LB  = 8'h5B;
  localparam logic [7:0] CH_NL  = 8'h0A;

  typedef struct packed {
    logic   keep;
    state_t next;
  } class_t;

  function automatic logic ends_plain(input logic [7:0] b);
    ends_plain = b inside {[8'h62:8'h79], [8'h42:8'h59], CH_AT};
  endfunction

endpackage

/* src/ansi_escape_stripper.sv */
`timescale 1ns / 1ps
// Terminal escape sequence stripper. Every input byte transfer yields exactly one
// result transfer that echoes the byte, flags in out_tuser whether it is kept, and
// copies tlast. One byte is taken per cycle while the output is not stalled. A byte
// passes an input register and then a result register on its way out, and the
// filter state is updated as the byte passes the classifier between them.
// Depends on aes_pkg and aes_classify.
module ansi_escape_stripper import aes_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] keep
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_keep_r;
  logic       out_last_r;
  logic       mode_r;
  state_t     state_r;
  state_t     state_nxt;
  class_t     cls;
  logic       out_free;
  logic       s1_move;
  logic       in_xfer;

  aes_classify u_classify (
    .byte_i  (s1_byte_r),
    .state_i (state_r),
    .mode_i  (mode_r),
    .res_o   (cls)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign state_nxt = s1_last_r ? ST_NORMAL : cls.next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b1;
      state_r     <= ST_NORMAL;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_move) begin
      out_byte_r <= s1_byte_r;
      out_keep_r <= cls.keep;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_keep_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/aes_classify.sv */
`timescale 1ns / 1ps
// Combinational classifier: decides the keep flag and the next filter state
// from one byte, the current state and the mode. Depends on aes_pkg.
module aes_classify import aes_pkg::*; (
  input  logic [7:0] byte_i,
  input  state_t     state_i,
  input  logic       mode_i,
  output class_t     res_o
);

  state_t plain_nxt;

  assign plain_nxt = ends_plain(byte_i) ? ST_NORMAL : ST_PLAIN;

  always_comb begin
    res_o.keep = 1'b0;
    res_o.next = ST_NORMAL;
    if (byte_i == CH_ESC) begin
      res_o.next = mode_i ? ST_ESC : ST_PLAIN;
    end else begin
      case (state_i)
        ST_ESC: begin
          if (mode_i && byte_i == CH_LT) begin
            res_o.next = ST_BRACKET;
          end else if (mode_i && byte_i == CH_LB) begin
            res_o.next = ST_ESC_LB;
          end else begin
            res_o.next = plain_nxt;
          end
        end
        ST_ESC_LB: begin
          if (mode_i && byte_i == CH_LT) begin
            res_o.next = ST_BRACKET;
          end else begin
            res_o.next = plain_nxt;
          end
        end
        ST_PLAIN: begin
          res_o.next = plain_nxt;
        end
        ST_BRACKET: begin
          res_o.next = (byte_i == CH_GT || byte_i == CH_NL) ? ST_NORMAL : ST_BRACKET;
        end
        default: begin
          res_o.keep = 1'b1;
          res_o.next = ST_NORMAL;
        end
      endcase
    end
  end

endmodule

/* src/aes_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the escape sequence stripper, bound to the top level.
// Depends on aes_pkg for the byte constants.
module aes_checker import aes_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_esc_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == CH_ESC |-> !out_tuser)
    else $error("escape byte marked as kept");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_esc_then_plain_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata == CH_ESC && !in_tlast && !out_tvalid &&
      !cfg_valid ##1 in_tvalid && in_tready && in_tdata == 8'h31 && !cfg_valid &&
      out_tready ##1 out_tready
      |=> out_tvalid && out_tdata == 8'h31 && !out_tuser)
    else $error("byte after escape kept");

endmodule

bind ansi_escape_stripper aes_checker u_aes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);
